// ===== rtl/isetbl_pkg.sv =====
// ----------------------------------------------------------------------------
// isetbl_pkg
// Shared types, codes and defaults of the interval set table.
// ----------------------------------------------------------------------------
`default_nettype none

package isetbl_pkg;

  // default geometry
  localparam int ENTRIES_DEF = 64;
  localparam int CLASSES_DEF = 4;

  // field widths fixed by the interface
  localparam int CMD_W    = 2;
  localparam int CLS_IN_W = 2;
  localparam int TIME_W   = 32;
  localparam int IDX_IN_W = 6;
  localparam int STAT_W   = 3;
  localparam int COUNT_W  = 7;
  localparam int CFG_IX_W = 1;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // result status codes
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_MERGED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd5;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_WIN_START = 1'd0;
  localparam logic [CFG_IX_W-1:0] CFG_WIN_END   = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new command
    logic init;      // reset scan pointers for the current class
    logic scan;      // stream one entry through the merge logic
    logic tail;      // final emit and count update of a class
    logic rd_issue;  // direct read of one entry
    logic done;      // result beat
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic add_skip;  // add that leaves the table alone
    logic abort;     // insert into a full class
    logic scan_end;  // all entries of the class processed
    logic last_cls;  // scan is on the last class
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/interval_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// interval_set_table_unit
// Sorted, disjoint interval lists per class with add, clear, flush and read.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low, and the result
// comes back as a single out_valid beat that must be captured that cycle,
// since the receiver cannot stall it. Each class is walked through one
// memory read port and one write port, one entry per cycle. An add scans
// the n entries held in its class and then appends in a tail step, and
// can end early when a full class rejects an insert; a clear walks every
// class in turn; a dropped add and a flush go straight to the result beat,
// and a read makes one direct read. A new command is taken in the cycle
// after the beat. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_table_unit #(
  parameter int ENTRIES = isetbl_pkg::ENTRIES_DEF,
  parameter int CLASSES = isetbl_pkg::CLASSES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [isetbl_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [isetbl_pkg::CLS_IN_W-1:0]     in_busy_class,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       in_interval_start,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       in_interval_end,
  input  wire logic [isetbl_pkg::IDX_IN_W-1:0]     in_entry_index,
  // result beat
  output logic                                     out_valid,
  output logic [isetbl_pkg::STAT_W-1:0]            out_status,
  output logic [isetbl_pkg::COUNT_W-1:0]           out_entry_count,
  output logic [isetbl_pkg::TIME_W-1:0]            out_read_start,
  output logic [isetbl_pkg::TIME_W-1:0]            out_read_end,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [isetbl_pkg::CFG_IX_W-1:0]     cfg_index,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       cfg_data
);

  isetbl_pkg::ctl_t ctl;
  isetbl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = ctl.done;

  isetbl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  isetbl_datapath #(
    .ENTRIES (ENTRIES),
    .CLASSES (CLASSES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_busy_class     (in_busy_class),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_entry_index    (in_entry_index),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_read_start    (out_read_start),
    .out_read_end      (out_read_end)
  );

endmodule

`default_nettype wire

// ===== rtl/isetbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// isetbl_ctrl
// Sequencer: steps each command from load to result beat, via scan/tail or read as needed.
// ----------------------------------------------------------------------------
`default_nettype none

module isetbl_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [isetbl_pkg::CMD_W-1:0]   in_cmd,
  input  wire isetbl_pkg::sts_t               sts,
  output isetbl_pkg::ctl_t                    ctl,
  output logic                                busy
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_SCAN = 6'b000100,
    S_TAIL = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  isetbl_pkg::cmd_t  op_r, op_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = isetbl_pkg::cmd_t'(in_cmd);
          case (isetbl_pkg::cmd_t'(in_cmd))
            isetbl_pkg::CMD_ADD:   state_nxt = sts.add_skip ? S_DONE : S_INIT;
            isetbl_pkg::CMD_CLEAR: state_nxt = S_INIT;
            isetbl_pkg::CMD_FLUSH: state_nxt = S_DONE;
            default:               state_nxt = S_READ;
          endcase
        end
      end
      S_INIT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.abort)         state_nxt = S_DONE;
        else if (sts.scan_end) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (op_r == isetbl_pkg::CMD_CLEAR && !sts.last_cls) state_nxt = S_INIT;
        else                                                  state_nxt = S_DONE;
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= isetbl_pkg::CMD_ADD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // commands
  assign ctl.load     = (state_r == S_IDLE) && start;
  assign ctl.init     = (state_r == S_INIT);
  assign ctl.scan     = (state_r == S_SCAN);
  assign ctl.tail     = (state_r == S_TAIL);
  assign ctl.rd_issue = (state_r == S_READ);
  assign ctl.done     = (state_r == S_DONE);
  assign busy         = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/isetbl_datapath.sv =====
// ----------------------------------------------------------------------------
// isetbl_datapath
// Interval memory, class counts, window registers and the streaming
// merge / clear logic. One entry read and at most one written per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module isetbl_datapath #(
  parameter int ENTRIES = isetbl_pkg::ENTRIES_DEF,
  parameter int CLASSES = isetbl_pkg::CLASSES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire isetbl_pkg::ctl_t                    ctl,
  output isetbl_pkg::sts_t                         sts,
  input  wire logic [isetbl_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [isetbl_pkg::CLS_IN_W-1:0]     in_busy_class,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       in_interval_start,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       in_interval_end,
  input  wire logic [isetbl_pkg::IDX_IN_W-1:0]     in_entry_index,
  input  wire logic                                cfg_we,
  input  wire logic [isetbl_pkg::CFG_IX_W-1:0]     cfg_index,
  input  wire logic [isetbl_pkg::TIME_W-1:0]       cfg_data,
  output logic [isetbl_pkg::STAT_W-1:0]            out_status,
  output logic [isetbl_pkg::COUNT_W-1:0]           out_entry_count,
  output logic [isetbl_pkg::TIME_W-1:0]            out_read_start,
  output logic [isetbl_pkg::TIME_W-1:0]            out_read_end
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int ADDR_W = CLS_W + IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CMP_W  = (CNT_W > isetbl_pkg::IDX_IN_W) ? CNT_W : isetbl_pkg::IDX_IN_W;
  localparam int TW     = isetbl_pkg::TIME_W;

  // add phases
  typedef enum logic [2:0] {
    PH_BEFORE = 3'b001,
    PH_MERGE  = 3'b010,
    PH_AFTER  = 3'b100
  } phase_t;

  // interval memory
  logic [TW-1:0] mem_s [DEPTH];
  logic [TW-1:0] mem_e [DEPTH];
  logic [TW-1:0] q_s_r, q_e_r;

  // config and class state
  logic [TW-1:0]    win_s_r, win_e_r;
  logic [CNT_W-1:0] counts_r [CLASSES];

  // latched command
  isetbl_pkg::cmd_t              op_r;
  logic [isetbl_pkg::CLS_IN_W-1:0] cls_r;
  logic                          cls_ok_r;
  logic [TW-1:0]                 s_r, e_r;
  logic [isetbl_pkg::IDX_IN_W-1:0] idx_r;
  logic                          skip_r;

  // scan state
  logic [CLS_W-1:0] scan_cls_r;
  logic [CNT_W-1:0] rd_ptr_r, wr_ptr_r;
  logic             dv_r;
  phase_t           ph_r, ph_nxt;
  logic [TW-1:0]    pend_s_r, pend_e_r, pend_s_nxt, pend_e_nxt;
  logic             merged_r, abort_r;

  // load-time decode
  logic          cls_ok_in;
  logic [TW-1:0] clip_s, clip_e;
  logic          add_skip;

  assign cls_ok_in = (int'(in_busy_class) < CLASSES);
  assign clip_s    = (in_interval_start < win_s_r) ? win_s_r : in_interval_start;
  assign clip_e    = (in_interval_end > win_e_r) ? win_e_r : in_interval_end;
  assign add_skip  = (in_busy_class == '0) || !cls_ok_in || (clip_e <= clip_s);

  // current class
  logic [CNT_W-1:0] n;
  logic             full, issue;
  assign n     = counts_r[scan_cls_r];
  assign full  = (n == CNT_W'(ENTRIES));
  assign issue = ctl.scan && (rd_ptr_r < n);

  // per-entry processing
  logic          emit, abort_now, merge_set;
  logic [TW-1:0] emit_s, emit_e, cs, ce;
  always_comb begin
    emit       = 1'b0;
    abort_now  = 1'b0;
    merge_set  = 1'b0;
    emit_s     = q_s_r;
    emit_e     = q_e_r;
    pend_s_nxt = pend_s_r;
    pend_e_nxt = pend_e_r;
    ph_nxt     = ph_r;
    cs         = (q_s_r > s_r) ? e_r : q_s_r;
    ce         = (q_e_r < e_r) ? s_r : q_e_r;
    if (op_r == isetbl_pkg::CMD_CLEAR) begin
      // keep disjoint entries, trim overlaps, drop what empties
      if (q_e_r < s_r || q_s_r > e_r) begin
        emit = 1'b1;
      end else if (cs < ce) begin
        emit   = 1'b1;
        emit_s = cs;
        emit_e = ce;
      end
    end else begin
      case (ph_r)
        PH_BEFORE: begin
          if (q_e_r < s_r) begin
            emit = 1'b1;
          end else if (q_s_r > e_r) begin
            if (full) begin
              abort_now = 1'b1;
            end else begin
              emit       = 1'b1;
              emit_s     = s_r;
              emit_e     = e_r;
              pend_s_nxt = q_s_r;
              pend_e_nxt = q_e_r;
              ph_nxt     = PH_AFTER;
            end
          end else begin
            merge_set  = 1'b1;
            pend_s_nxt = (s_r < q_s_r) ? s_r : q_s_r;
            pend_e_nxt = (e_r > q_e_r) ? e_r : q_e_r;
            ph_nxt     = PH_MERGE;
          end
        end
        PH_MERGE: begin
          if (pend_e_r >= q_s_r) begin
            if (q_e_r > pend_e_r) pend_e_nxt = q_e_r;
          end else begin
            emit       = 1'b1;
            emit_s     = pend_s_r;
            emit_e     = pend_e_r;
            pend_s_nxt = q_s_r;
            pend_e_nxt = q_e_r;
            ph_nxt     = PH_AFTER;
          end
        end
        default: begin
          emit       = 1'b1;
          emit_s     = pend_s_r;
          emit_e     = pend_e_r;
          pend_s_nxt = q_s_r;
          pend_e_nxt = q_e_r;
        end
      endcase
    end
  end

  // tail of a class: append or flush the pending entry
  logic             tail_add, tail_full, tail_we;
  logic [TW-1:0]    tail_s, tail_e;
  logic [CNT_W-1:0] tail_count;
  assign tail_add   = (op_r == isetbl_pkg::CMD_ADD);
  assign tail_full  = tail_add && (ph_r == PH_BEFORE) && full;
  assign tail_we    = tail_add && !tail_full;
  assign tail_s     = (ph_r == PH_BEFORE) ? s_r : pend_s_r;
  assign tail_e     = (ph_r == PH_BEFORE) ? e_r : pend_e_r;
  assign tail_count = tail_add ? (wr_ptr_r + CNT_W'(1)) : wr_ptr_r;

  // memory port control
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [TW-1:0]     wdata_s, wdata_e;
  logic              step_we;
  assign step_we = ctl.scan && dv_r && emit && !abort_now;
  assign mem_we  = step_we || (ctl.tail && tail_we);
  assign waddr   = {scan_cls_r, wr_ptr_r[IDX_W-1:0]};
  assign wdata_s = ctl.tail ? tail_s : emit_s;
  assign wdata_e = ctl.tail ? tail_e : emit_e;
  assign raddr   = ctl.rd_issue ? {scan_cls_r, IDX_W'(idx_r)}
                                : {scan_cls_r, rd_ptr_r[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_s[waddr] <= wdata_s;
      mem_e[waddr] <= wdata_e;
    end
    q_s_r <= mem_s[raddr];
    q_e_r <= mem_e[raddr];
  end

  // window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_s_r <= '0;
      win_e_r <= '1;
    end else if (cfg_we) begin
      if (cfg_index == isetbl_pkg::CFG_WIN_START) win_s_r <= cfg_data;
      if (cfg_index == isetbl_pkg::CFG_WIN_END)   win_e_r <= cfg_data;
    end
  end

  // class counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CLASSES; k++) counts_r[k] <= '0;
    end else if (ctl.load && isetbl_pkg::cmd_t'(in_cmd) == isetbl_pkg::CMD_FLUSH) begin
      for (int k = 0; k < CLASSES; k++) counts_r[k] <= '0;
    end else if (ctl.tail && !tail_full) begin
      counts_r[scan_cls_r] <= tail_count;
    end
  end

  // command latch and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r     <= 1'b0;
      merged_r <= 1'b0;
      abort_r  <= 1'b0;
      ph_r     <= PH_BEFORE;
    end else begin
      dv_r <= issue;
      if (ctl.load) begin
        merged_r <= 1'b0;
        abort_r  <= 1'b0;
      end
      if (ctl.init) ph_r <= PH_BEFORE;
      if (ctl.scan && dv_r) begin
        ph_r <= ph_nxt;
        if (merge_set) merged_r <= 1'b1;
        if (abort_now) abort_r  <= 1'b1;
      end
      if (ctl.tail && tail_full) abort_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r     <= isetbl_pkg::cmd_t'(in_cmd);
      cls_r    <= in_busy_class;
      cls_ok_r <= cls_ok_in;
      idx_r    <= in_entry_index;
      skip_r   <= add_skip;
      if (isetbl_pkg::cmd_t'(in_cmd) == isetbl_pkg::CMD_ADD) begin
        s_r <= clip_s;
        e_r <= clip_e;
      end else begin
        s_r <= in_interval_start;
        e_r <= in_interval_end;
      end
      if (isetbl_pkg::cmd_t'(in_cmd) == isetbl_pkg::CMD_CLEAR) scan_cls_r <= '0;
      else                                                     scan_cls_r <= CLS_W'(in_busy_class);
    end
    if (ctl.init) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end
    if (issue) rd_ptr_r <= rd_ptr_r + CNT_W'(1);
    if (step_we) wr_ptr_r <= wr_ptr_r + CNT_W'(1);
    if (ctl.scan && dv_r) begin
      pend_s_r <= pend_s_nxt;
      pend_e_r <= pend_e_nxt;
    end
    // clear walks the classes in turn, then points back at the addressed one
    if (ctl.tail && op_r == isetbl_pkg::CMD_CLEAR) begin
      if (sts.last_cls) scan_cls_r <= CLS_W'(cls_r);
      else              scan_cls_r <= scan_cls_r + CLS_W'(1);
    end
  end

  // status to controller
  assign sts.add_skip = add_skip;
  assign sts.abort    = ctl.scan && dv_r && abort_now;
  assign sts.scan_end = !dv_r && (rd_ptr_r >= n);
  assign sts.last_cls = (scan_cls_r == CLS_W'(CLASSES - 1));

  // result
  logic idx_ok;
  assign idx_ok = (CMP_W'(idx_r) < CMP_W'(n));

  always_comb begin
    case (op_r)
      isetbl_pkg::CMD_ADD: begin
        if (skip_r)        out_status = isetbl_pkg::ST_IGNORED;
        else if (abort_r)  out_status = isetbl_pkg::ST_FULL;
        else if (merged_r) out_status = isetbl_pkg::ST_MERGED;
        else               out_status = isetbl_pkg::ST_INSERTED;
      end
      isetbl_pkg::CMD_CLEAR, isetbl_pkg::CMD_FLUSH: out_status = isetbl_pkg::ST_CLEARED;
      default: begin
        if (!cls_ok_r)   out_status = isetbl_pkg::ST_IGNORED;
        else if (idx_ok) out_status = isetbl_pkg::ST_READ_OK;
        else             out_status = isetbl_pkg::ST_BAD_INDEX;
      end
    endcase
  end

  assign out_entry_count = cls_ok_r ? isetbl_pkg::COUNT_W'(n) : '0;
  assign out_read_start  = (out_status == isetbl_pkg::ST_READ_OK) ? q_s_r : '0;
  assign out_read_end    = (out_status == isetbl_pkg::ST_READ_OK) ? q_e_r : '0;

endmodule

`default_nettype wire
